>>> rtl/iwom_pkg.sv
// ----------------------------------------------------------------------------
// iwom_pkg
// Shared types, constants and month tables for the week-of-month-start block.
// ----------------------------------------------------------------------------
`default_nettype none

package iwom_pkg;

  // Year-dependent quantities produced by the year unit.
  // day_count is z + z/4 - z/100 + z/400 with z = year + 399.
  typedef struct packed {
    logic [14:0] day_count;
    logic        leap;
    logic        prev_leap;
  } year_info_t;

  // Reciprocal of 25 scaled by 2^17, exact for dividends below 43690.
  localparam logic [12:0] RECIP25      = 13'd5243;
  localparam int          RECIP25_SHIFT = 17;
  // Reciprocal of 7 scaled by 2^11, exact for dividends up to 341.
  localparam logic [8:0]  RECIP7       = 9'd293;
  localparam int          RECIP7_SHIFT = 11;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [2:0] WD_THURSDAY = 3'd3;
  localparam logic [2:0] WD_FRIDAY   = 3'd4;
  localparam logic [2:0] WD_SATURDAY = 3'd5;

  localparam logic [5:0] WEEK_FIRST = 6'd1;
  localparam logic [5:0] WEEK_52    = 6'd52;
  localparam logic [5:0] WEEK_53    = 6'd53;

  // Days before the 1st of the month in a common year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of the month in a common year.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
      4'd2:                                       d = 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  // Weekday offset of the 1st of the month relative to 1 January of a
  // common year (0 = Monday based), folded mod 7.
  function automatic logic [2:0] month_offset(input logic [3:0] m);
    logic [2:0] d;
    case (m)
      4'd1:    d = 3'd0;
      4'd2:    d = 3'd3;
      4'd3:    d = 3'd3;
      4'd4:    d = 3'd6;
      4'd5:    d = 3'd1;
      4'd6:    d = 3'd4;
      4'd7:    d = 3'd6;
      4'd8:    d = 3'd2;
      4'd9:    d = 3'd5;
      4'd10:   d = 3'd0;
      4'd11:   d = 3'd3;
      4'd12:   d = 3'd5;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/iwom_year_unit.sv
// ----------------------------------------------------------------------------
// iwom_year_unit
// Three-stage year arithmetic: day count of the shifted year and leap flags.
// ----------------------------------------------------------------------------
`default_nettype none

module iwom_year_unit
  import iwom_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [13:0] year,
  output year_info_t       info
);

  // Stage A: shifted year z = year + 399 (same weekdays as year - 1).
  logic [14:0] z_a;

  // Stage B: quarter and sixteenth of z with their reciprocal products.
  logic [14:0] z_b;
  logic [12:0] q4_b;
  logic [10:0] q16_b;
  logic [24:0] p100_b;
  logic [22:0] p400_b;

  logic [12:0] q4_a;
  logic [10:0] q16_a;

  // Stage C results.
  logic [7:0]  q100;
  logic [5:0]  q400;
  logic [12:0] r100;
  logic [10:0] r400;
  logic        z4, z100, z400, y4, y100, y400;
  logic [14:0] count_next;

  assign q4_a  = z_a[14:2];
  assign q16_a = z_a[14:4];

  always_ff @(posedge clk) begin
    if (en) begin
      z_a    <= {1'b0, year} + 15'd399;
      z_b    <= z_a;
      q4_b   <= q4_a;
      q16_b  <= q16_a;
      p100_b <= 25'(q4_a * RECIP25);
      p400_b <= 23'(q16_a * RECIP25);
    end
  end

  always_comb begin
    q100 = p100_b[RECIP25_SHIFT +: 8];
    q400 = p400_b[RECIP25_SHIFT +: 6];
    // Remainders mod 25 of z/4 and z/16, with 25x as 16x + 8x + x.
    r100 = q4_b - ({5'd0, q100} + {2'd0, q100, 3'd0} + {1'b0, q100, 4'd0});
    r400 = q16_b - ({5'd0, q400} + {2'd0, q400, 3'd0} + {1'b0, q400, 4'd0});
    // Leap flags of z (the year before) and z + 1 (the year itself).
    z4   = (z_b[1:0] == 2'd0);
    z100 = z4 && (r100 == 13'd0);
    z400 = (z_b[3:0] == 4'd0) && (r400 == 11'd0);
    y4   = (z_b[1:0] == 2'd3);
    y100 = y4 && (r100 == 13'd24);
    y400 = (z_b[3:0] == 4'd15) && (r400 == 11'd24);
    count_next = z_b + {2'd0, q4_b} - {7'd0, q100} + {9'd0, q400};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info.day_count <= count_next;
      info.leap      <= (y4 && !y100) || y400;
      info.prev_leap <= (z4 && !z100) || z400;
    end
  end

endmodule

`default_nettype wire

>>> rtl/iso_week_of_month_start.sv
// ----------------------------------------------------------------------------
// iso_week_of_month_start
// ISO 8601 week number, weekday and length of a Gregorian month's first day.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   request  req_valid/req_stall   month[3:0], year[13:0]
//   result   rsp_valid/rsp_stall   week_number[5:0], first_weekday[2:0],
//                                  days_in_month[4:0], bad_month
//
// Every item passes five register stages. The first stage loads at the edge
// that accepts the item, and the last one is the output register. The
// stages are three of year arithmetic (offset add, reciprocal multiplies,
// day count), one weekday stage and one week/length stage. One item is
// accepted in every cycle unless req_stall is raised; the whole pipeline
// advances together.
// When a result waits under rsp_stall the pipeline holds and req_stall is
// raised, so no item is lost or repeated. Synchronous reset clears the
// valid bits of all stages; the payload registers are not reset.
// A month outside 1 to 12 gives bad_month and zeros in the other fields.
// ----------------------------------------------------------------------------
`default_nettype none

module iso_week_of_month_start
  import iwom_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [3:0]  month,
  input  wire logic [13:0] year,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [5:0]       week_number,
  output logic [2:0]       first_weekday,
  output logic [4:0]       days_in_month,
  output logic             bad_month
);

  localparam int YEAR_STAGES = 3;

  // The pipeline moves whenever the output register is free or being taken.
  logic advance;
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = !advance;

  // Month and valid bits travel alongside the year unit's three stages.
  logic [3:0] mon_pipe [YEAR_STAGES];
  logic [YEAR_STAGES-1:0] vld_pipe;

  year_info_t info;

  iwom_year_unit u_year (
    .clk  (clk),
    .en   (advance),
    .year (year),
    .info (info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else if (advance) begin
      vld_pipe <= {vld_pipe[YEAR_STAGES-2:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mon_pipe[0] <= month;
      for (int i = 1; i < YEAR_STAGES; i++) begin
        mon_pipe[i] <= mon_pipe[i-1];
      end
    end
  end

  // Weekday stage. The day count mod 7 is the weekday of 1 January
  // (0 = Monday); octal digits are summed since 8 is 1 mod 7.
  logic [3:0] mon_c;
  logic [5:0] digit_sum;
  logic [3:0] fold;
  logic [2:0] jan1_next;
  logic [3:0] wd_sum;
  logic [2:0] wd_next;

  assign mon_c = mon_pipe[YEAR_STAGES-1];

  always_comb begin
    digit_sum = {3'd0, info.day_count[2:0]} + {3'd0, info.day_count[5:3]}
              + {3'd0, info.day_count[8:6]} + {3'd0, info.day_count[11:9]}
              + {3'd0, info.day_count[14:12]};
    fold      = {1'b0, digit_sum[2:0]} + {1'b0, digit_sum[5:3]};
    jan1_next = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];
    // From March on, a leap year pushes the weekday one further.
    wd_sum    = {1'b0, jan1_next} + {1'b0, month_offset(mon_c)}
              + {3'd0, info.leap && (mon_c > MONTH_FEB)};
    wd_next   = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
  end

  logic       vld_d;
  logic [3:0] mon_d;
  logic [2:0] jan1_d;
  logic [2:0] wd_d;
  logic       leap_d;
  logic       prev_leap_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
    end else if (advance) begin
      vld_d <= vld_pipe[YEAR_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mon_d       <= mon_c;
      jan1_d      <= jan1_next;
      wd_d        <= wd_next;
      leap_d      <= info.leap;
      prev_leap_d <= info.prev_leap;
    end
  end

  // Week and length stage. For February on, the day of the year of the 1st
  // is shifted by the weekday of 1 January and divided by 7 through a
  // reciprocal. January falls in week 1 or in the last week of the year
  // before, which has 53 weeks when that year began on a Thursday, or on a
  // Wednesday in a leap year.
  logic       bad_next;
  logic [8:0] doy;
  logic [8:0] shifted;
  logic [17:0] quot_prod;
  logic [5:0] week_next;
  logic [4:0] len_next;

  always_comb begin
    bad_next  = (mon_d < MONTH_JAN) || (mon_d > MONTH_DEC);
    doy       = days_before(mon_d) + {8'd0, leap_d && (mon_d > MONTH_FEB)};
    shifted   = (jan1_d <= WD_THURSDAY) ? doy + {6'd0, jan1_d}
                                        : doy + {6'd0, jan1_d} - 9'd7;
    quot_prod = 18'(shifted * RECIP7);
    if (mon_d == MONTH_JAN) begin
      if (jan1_d <= WD_THURSDAY) begin
        week_next = WEEK_FIRST;
      end else if (jan1_d == WD_FRIDAY || (jan1_d == WD_SATURDAY && prev_leap_d)) begin
        week_next = WEEK_53;
      end else begin
        week_next = WEEK_52;
      end
    end else begin
      week_next = quot_prod[RECIP7_SHIFT +: 6] + 6'd1;
    end
    len_next = month_len(mon_d) + {4'd0, leap_d && (mon_d == MONTH_FEB)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= vld_d;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bad_month     <= bad_next;
      week_number   <= bad_next ? 6'd0 : week_next;
      first_weekday <= bad_next ? 3'd0 : wd_d;
      days_in_month <= bad_next ? 5'd0 : len_next;
    end
  end

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ISO week-of-month-start block.
//
// Date queries (month, year) go in through the request channel and each
// accepted item is predicted here: the ISO week that holds the first of the
// month, that day's weekday, the month length and the invalid-month flag.
// Results are matched in order against these predictions. A directed set
// covers the edge cases. Random sets follow, with idle cycles on both sides,
// and one stretch runs at full rate with no idling at all.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;
  // The pipeline is five stages deep; the final pause is well past that.
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_PERCENT = 23;

  localparam logic [3:0] JANUARY  = 4'd1;
  localparam logic [3:0] FEBRUARY = 4'd2;
  localparam logic [3:0] DECEMBER = 4'd12;

  // Weekday codes, Monday first.
  localparam int unsigned THURSDAY = 3;
  localparam int unsigned FRIDAY   = 4;
  localparam int unsigned SATURDAY = 5;

  typedef struct packed {
    logic [5:0] week;
    logic [2:0] weekday;
    logic [4:0] length;
    logic       bad;
  } month_start_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [3:0]  month = 4'd0;
  logic [13:0] year = 14'd0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [5:0]  week_number;
  logic [2:0]  first_weekday;
  logic [4:0]  days_in_month;
  logic        bad_month;

  // Predicted results still waiting for the block, oldest first.
  month_start_t pending_starts[$];

  // Days before the first of each month in a common year; index 1 to 12.
  int unsigned days_ahead[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243,
                                  273, 304, 334};

  int unsigned errors = 0;
  int unsigned dates_accepted = 0;
  int unsigned invalid_months = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  // While set, neither side of the bench inserts idle or stall cycles.
  bit steady_flow = 1'b0;

  iso_week_of_month_start dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .month         (month),
    .year          (year),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .week_number   (week_number),
    .first_weekday (first_weekday),
    .days_in_month (days_in_month),
    .bad_month     (bad_month)
  );

  always #4 clk = ~clk;

  // Gregorian leap rule, applied to any non-negative year.
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Weekday of the first of month m, 0 for Monday. The year is moved up by
  // 400, a whole Gregorian cycle, so the divisions never see a negative value.
  function automatic int unsigned weekday_of_first(input int unsigned m,
                                                   input int unsigned y);
    int unsigned shifted_year;
    int unsigned prior;
    int unsigned sum;
    shifted_year = y + 400;
    if (m < 3) begin
      // January and February count as months of the year before.
      prior = shifted_year - 1;
      sum = 23 * m / 9 + 5 + shifted_year + prior / 4 - prior / 100 + prior / 400;
    end else begin
      sum = 23 * m / 9 + 3 + shifted_year + shifted_year / 4 - shifted_year / 100
            + shifted_year / 400;
    end
    return ((sum % 7) + 6) % 7;
  endfunction

  // Expected result for one date query.
  function automatic month_start_t predict_month_start(input logic [3:0] m,
                                                       input logic [13:0] y);
    month_start_t r;
    int unsigned jan1;
    int unsigned day_of_year;
    int unsigned aligned;
    int unsigned len;
    bit leap;
    bit prev_leap;
    r = '0;
    if (m < JANUARY || m > DECEMBER) begin
      r.bad = 1'b1;
      return r;
    end
    leap = leap_year(y);
    jan1 = weekday_of_first(JANUARY, y);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 30;
      FEBRUARY:                len = leap ? 29 : 28;
      default:                 len = 31;
    endcase
    if (m == JANUARY) begin
      if (jan1 <= THURSDAY) begin
        r.week = 6'd1;
      end else begin
        // The first of January belongs to the last week of the year before.
        // The year before year 0 is taken as a common year.
        prev_leap = (y == 0) ? 1'b0 : leap_year(y - 1);
        if (jan1 == FRIDAY || (jan1 == SATURDAY && prev_leap)) begin
          r.week = 6'd53;
        end else begin
          r.week = 6'd52;
        end
      end
    end else begin
      day_of_year = days_ahead[m] + ((leap && m > FEBRUARY) ? 1 : 0);
      // Week one starts on the Monday of the week that holds the first
      // Thursday; shift the day count onto that grid.
      aligned = (jan1 <= THURSDAY) ? day_of_year + jan1 : day_of_year + jan1 - 7;
      r.week = 6'(aligned / 7 + 1);
    end
    r.weekday = 3'(weekday_of_first(m, y));
    r.length = 5'(len);
    return r;
  endfunction

  // Receiver side: stall at random, except during the steady stretch.
  always @(posedge clk) begin
    rsp_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Both handshakes are sampled here at the clock edge. An accepted request
  // is predicted before any result of the same edge is checked.
  always @(posedge clk) begin
    month_start_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        pending_starts.push_back(predict_month_start(month, year));
        dates_accepted++;
        if (month < JANUARY || month > DECEMBER) begin
          invalid_months++;
        end
      end
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (pending_starts.size() == 0) begin
          $error("result with no query waiting: week %0d weekday %0d days %0d bad %0d",
                 week_number, first_weekday, days_in_month, bad_month);
          errors++;
        end else begin
          want = pending_starts.pop_front();
          if (week_number !== want.week) begin
            $error("week_number: expected %0d, got %0d", want.week, week_number);
            errors++;
          end
          if (first_weekday !== want.weekday) begin
            $error("first_weekday: expected %0d, got %0d", want.weekday, first_weekday);
            errors++;
          end
          if (days_in_month !== want.length) begin
            $error("days_in_month: expected %0d, got %0d", want.length, days_in_month);
            errors++;
          end
          if (bad_month !== want.bad) begin
            $error("bad_month: expected %0d, got %0d", want.bad, bad_month);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one date query and returns at the edge where it is taken. Idle
  // cycles may come first; the payload holds steady while stalled.
  task automatic send_date(input logic [3:0] m, input logic [13:0] y);
    while (!steady_flow && ($urandom_range(99) < IDLE_PERCENT)) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    month <= m;
    year <= y;
    do @(posedge clk); while (req_stall);
  endtask

  // A random query: mostly valid months in the nominal year range, with
  // invalid months and the full 14-bit year range mixed in.
  task automatic send_random_date();
    logic [3:0] m;
    logic [13:0] y;
    if ($urandom_range(99) < 10) begin
      m = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
    end else begin
      m = 4'($urandom_range(12, 1));
    end
    if ($urandom_range(99) < 85) begin
      y = 14'($urandom_range(9999, 1));
    end else begin
      y = 14'($urandom_range(16383, 0));
    end
    send_date(m, y);
  endtask

  // Edge cases: invalid months, every January rule, leap rules and the
  // extremes of both fields.
  task automatic test_directed();
    send_date(4'd0, 14'd2024);      // invalid month, low side
    send_date(4'd13, 14'd2024);     // invalid month, just past December
    send_date(4'd15, 14'd16383);    // all input bits set
    send_date(4'd0, 14'd0);         // all input bits clear
    send_date(JANUARY, 14'd2018);   // January 1st on a Monday
    send_date(JANUARY, 14'd2020);   // on a Wednesday
    send_date(JANUARY, 14'd2015);   // on a Thursday, still week one
    send_date(JANUARY, 14'd2021);   // on a Friday, week 53 of the year before
    send_date(JANUARY, 14'd2005);   // Saturday after a leap year: week 53
    send_date(JANUARY, 14'd2022);   // Saturday after a common year: week 52
    send_date(JANUARY, 14'd2017);   // on a Sunday: week 52
    send_date(JANUARY, 14'd0);      // year 0, whose year before is common
    send_date(JANUARY, 14'd1);
    send_date(FEBRUARY, 14'd2000);  // leap by the 400-year rule
    send_date(FEBRUARY, 14'd1900);  // common by the 100-year rule
    send_date(FEBRUARY, 14'd2024);
    send_date(FEBRUARY, 14'd2023);
    send_date(FEBRUARY, 14'd0);     // year 0 is a leap year
    send_date(4'd3, 14'd2024);      // first month after a leap day
    send_date(DECEMBER, 14'd2024);
    send_date(DECEMBER, 14'd9999);  // end of the nominal year range
    send_date(4'd4, 14'd10000);     // beyond the nominal range
    send_date(4'd8, 14'd8191);
    send_date(4'd11, 14'd1);
    send_date(4'd7, 14'd16383);     // largest year the port can carry
  endtask

  // Random queries with idle cycles and stalls on both sides.
  task automatic test_random_dates(input int unsigned count);
    repeat (count) send_random_date();
  endtask

  // The year boundary: January, February and December of random years,
  // where the week count of the year before matters most.
  task automatic test_year_turn(input int unsigned count);
    logic [3:0] m;
    repeat (count) begin
      case ($urandom_range(2))
        0:       m = JANUARY;
        1:       m = FEBRUARY;
        default: m = DECEMBER;
      endcase
      send_date(m, 14'($urandom_range(16383, 0)));
    end
  endtask

  // A long stretch at full rate: a query on every cycle, no stalls.
  task automatic test_full_rate(input int unsigned count);
    steady_flow = 1'b1;
    repeat (count) send_random_date();
    steady_flow = 1'b0;
  endtask

  // Lowers the request valid, waits for every predicted result, then lets
  // the pipeline run empty for a while so a stray result would show up.
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_starts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_dates(400);
    test_year_turn(120);
    test_full_rate(250);
    drain();

    if (pending_starts.size() != 0) begin
      $error("%0d predicted results never arrived", pending_starts.size());
      errors++;
    end
    $display("Ran %0d date queries through the block, %0d with an invalid month,",
             dates_accepted, invalid_months);
    $display("and compared %0d results field by field; %0d mismatches.",
             results_seen, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
